// ===== src/bf_pkg.sv =====
// Shared types, constants and command structs for the Blowfish engine.
package bf_pkg;

    // Table layout
    localparam int TABLE_WORDS_DEF = 1042;
    localparam int P_WORDS         = 18;
    localparam int SBOX_WORDS      = 256;
    localparam int ROUNDS          = 16;
    localparam int RW_PAIRS        = 520;
    localparam logic [3:0] WRAP_RESET = 4'd12;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_KEY  = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEED,
        ST_STEP,
        ST_C_START,
        ST_C_ADDR,
        ST_C_MIX,
        ST_C_FIN_LO,
        ST_C_FIN_HI,
        ST_KW_CMT,
        ST_PMIX,
        ST_RW_HI,
        ST_RW_LO,
        ST_RESP
    } state_t;

    // What the running cipher pass works for; also selects its source block
    typedef enum logic [1:0] {
        PH_USER,
        PH_KW12,
        PH_KW01,
        PH_RW
    } phase_t;

    // Table write source
    typedef enum logic [1:0] {
        TW_IN,
        TW_HI,
        TW_LO
    } tw_src_t;

    // Key word update
    typedef enum logic [2:0] {
        KW_NONE,
        KW_SEED,
        KW_CMT12,
        KW_CMT01,
        KW_SHIFT
    } kw_op_t;

    typedef struct packed {
        logic        start;
        phase_t      src;
        logic        addr;
        logic        mix;
        logic        fin_lo;
        logic        fin_hi;
        logic [4:0]  p_idx;
        logic        tw_we;
        tw_src_t     tw_src;
        logic [9:0]  pair;
        kw_op_t      kw_op;
        logic        pmix;
        logic        byte_clr;
        logic        blk_clr;
    } cmd_t;

    typedef struct packed {
        logic        in_valid;
        op_t         in_op;
        logic        out_ready;
        op_t         op;
        logic [1:0]  level;
    } status_t;

endpackage

// ===== src/bf_req_if.sv =====
// Request channel: one operation with its operands.
interface bf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [10:0] table_index;
    logic [31:0] table_data;
    logic [31:0] block_low;
    logic [31:0] block_high;
    logic [31:0] id_code;
    logic [1:0]  key_level;

    modport source (output valid, operation, table_index, table_data, block_low,
                    block_high, id_code, key_level, input ready);
    modport sink (input valid, operation, table_index, table_data, block_low,
                  block_high, id_code, key_level, output ready);
endinterface

// ===== src/bf_res_if.sv =====
// Result channel: one 64-bit block per request.
interface bf_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_low;
    logic [31:0] out_high;

    modport source (output valid, out_low, out_high, input ready);
    modport sink (input valid, out_low, out_high, output ready);
endinterface

// ===== src/bf_datapath.sv =====
// Datapath: P registers, S-box memories, round function, key words and result.
module bf_datapath #(
    parameter int TABLE_WORDS = bf_pkg::TABLE_WORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cap,
    input  logic [1:0]      in_operation,
    input  logic [10:0]     in_table_index,
    input  logic [31:0]     in_table_data,
    input  logic [31:0]     in_block_low,
    input  logic [31:0]     in_block_high,
    input  logic [31:0]     in_id_code,
    input  logic [1:0]      in_key_level,
    input  logic            key_wrap_we,
    input  logic [3:0]      key_wrap_data,
    input  bf_pkg::cmd_t    cmd,
    output bf_pkg::op_t     op,
    output logic [1:0]      level,
    output logic [31:0]     out_low,
    output logic [31:0]     out_high
);

    function automatic logic [31:0] swap_bytes(input logic [31:0] m);
        swap_bytes = {m[7:0], m[15:8], m[23:16], m[31:24]};
    endfunction

    // Captured request
    bf_pkg::op_t  op_reg;
    logic [1:0]   level_reg;
    logic [10:0]  idx_reg;
    logic [31:0]  data_reg;
    logic [31:0]  lo_in_reg;
    logic [31:0]  hi_in_reg;
    logic [31:0]  id_reg;

    logic [3:0]   key_wrap_reg;
    logic [31:0]  kw_reg [3];
    logic [3:0]   byte_reg;
    logic [3:0]   byte_next;

    logic [31:0]  p_reg [bf_pkg::P_WORDS];
    logic [31:0]  p_rd;
    logic [31:0]  x_reg;
    logic [31:0]  y_reg;
    logic [31:0]  z_reg;
    logic [31:0]  blk_lo_reg;
    logic [31:0]  blk_hi_reg;
    logic [31:0]  rd_reg [4];

    logic [31:0]  z_now;
    logic [31:0]  f_val;
    logic [31:0]  src_lo;
    logic [31:0]  src_hi;
    logic [31:0]  kw_mix;
    logic [3:0]   wrap_eff;

    logic [10:0]  tw_addr;
    logic [31:0]  tw_data;
    logic         tw_in_range;
    logic         tw_is_p;
    logic [10:0]  tw_off;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= bf_pkg::OP_LOAD;
            level_reg <= 2'd0;
        end
        else if (cap)
        begin
            op_reg    <= bf_pkg::op_t'(in_operation);
            level_reg <= in_key_level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            idx_reg   <= in_table_index;
            data_reg  <= in_table_data;
            lo_in_reg <= in_block_low;
            hi_in_reg <= in_block_high;
            id_reg    <= in_id_code;
        end
    end

    assign op    = op_reg;
    assign level = level_reg;

    // Hold the wrap register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_wrap_reg <= bf_pkg::WRAP_RESET;
        else if (key_wrap_we)
            key_wrap_reg <= key_wrap_data;
    end

    assign wrap_eff = (key_wrap_reg == 4'd0) ? bf_pkg::WRAP_RESET : key_wrap_reg;

    // Advance the byte offset by four, modulo the wrap
    always_comb
    begin
        logic [4:0] b;
        b = {1'b0, byte_reg} + 5'd4;
        for (int i = 0; i < 4; i++)
        begin
            if (b >= {1'b0, wrap_eff})
                b = b - {1'b0, wrap_eff};
        end
        byte_next = b[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= 4'd0;
        else if (cmd.byte_clr)
            byte_reg <= 4'd0;
        else if (cmd.pmix)
            byte_reg <= byte_next;
    end

    assign kw_mix = (byte_reg[3:2] == 2'd3) ? 32'd0 : kw_reg[byte_reg[3:2]];

    // Update key words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg[0] <= 32'd0;
            kw_reg[1] <= 32'd0;
            kw_reg[2] <= 32'd0;
        end
        else
        begin
            case (cmd.kw_op)
                bf_pkg::KW_SEED:
                begin
                    kw_reg[0] <= id_reg;
                    kw_reg[1] <= id_reg >> 1;
                    kw_reg[2] <= id_reg << 1;
                end
                bf_pkg::KW_CMT12:
                begin
                    kw_reg[1] <= blk_lo_reg;
                    kw_reg[2] <= blk_hi_reg;
                end
                bf_pkg::KW_CMT01:
                begin
                    kw_reg[0] <= blk_lo_reg;
                    kw_reg[1] <= blk_hi_reg;
                end
                bf_pkg::KW_SHIFT:
                begin
                    kw_reg[1] <= kw_reg[1] << 1;
                    kw_reg[2] <= kw_reg[2] >> 1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Decode the table write
    always_comb
    begin
        case (cmd.tw_src)
            bf_pkg::TW_HI:
            begin
                tw_addr = {cmd.pair, 1'b0};
                tw_data = blk_hi_reg;
            end
            bf_pkg::TW_LO:
            begin
                tw_addr = {cmd.pair, 1'b1};
                tw_data = blk_lo_reg;
            end
            default:
            begin
                tw_addr = idx_reg;
                tw_data = data_reg;
            end
        endcase
    end

    assign tw_in_range = 32'(tw_addr) < 32'(TABLE_WORDS);
    assign tw_is_p     = tw_addr < 11'(bf_pkg::P_WORDS);
    assign tw_off      = tw_addr - 11'(bf_pkg::P_WORDS);

    // P registers: one read port, written by loads, rewrites and key mixing
    assign p_rd = p_reg[cmd.p_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.tw_we && tw_in_range && tw_is_p)
            p_reg[tw_addr[4:0]] <= tw_data;
        else if (cmd.pmix)
            p_reg[cmd.p_idx] <= p_rd ^ swap_bytes(kw_mix);
    end

    assign z_now = p_rd ^ x_reg;

    // S-box memories, one read per round each
    for (genvar g = 0; g < 4; g++)
    begin : g_sbox
        logic [31:0] mem [bf_pkg::SBOX_WORDS];

        always_ff @(posedge clk)
        begin
            if (cmd.tw_we && tw_in_range && !tw_is_p && tw_off[9:8] == 2'(g))
                mem[tw_off[7:0]] <= tw_data;
            if (cmd.addr)
                rd_reg[g] <= mem[z_now[31 - 8 * g -: 8]];
        end
    end

    assign f_val = ((rd_reg[0] + rd_reg[1]) ^ rd_reg[2]) + rd_reg[3];

    // Select the block that enters the cipher
    always_comb
    begin
        case (cmd.src)
            bf_pkg::PH_KW12:
            begin
                src_lo = kw_reg[1];
                src_hi = kw_reg[2];
            end
            bf_pkg::PH_KW01:
            begin
                src_lo = kw_reg[0];
                src_hi = kw_reg[1];
            end
            bf_pkg::PH_RW:
            begin
                src_lo = blk_lo_reg;
                src_hi = blk_hi_reg;
            end
            default:
            begin
                src_lo = lo_in_reg;
                src_hi = hi_in_reg;
            end
        endcase
    end

    // Round registers and result block
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            y_reg <= src_lo;
            x_reg <= src_hi;
        end
        else if (cmd.mix)
        begin
            x_reg <= f_val ^ y_reg;
            y_reg <= z_reg;
        end
        if (cmd.addr)
            z_reg <= z_now;
        if (cmd.blk_clr)
        begin
            blk_lo_reg <= 32'd0;
            blk_hi_reg <= 32'd0;
        end
        else
        begin
            if (cmd.fin_lo)
                blk_lo_reg <= x_reg ^ p_rd;
            if (cmd.fin_hi)
                blk_hi_reg <= y_reg ^ p_rd;
        end
    end

    assign out_low  = blk_lo_reg;
    assign out_high = blk_hi_reg;

endmodule

// ===== src/bf_ctrl.sv =====
// Controller: sequences requests, cipher rounds and key schedule passes.
module bf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  bf_pkg::status_t  status,
    output bf_pkg::cmd_t     cmd,
    output logic             in_ready,
    output logic             out_valid
);

    bf_pkg::state_t  state_reg, state_next;
    bf_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]      rnd_reg, rnd_next;
    logic [4:0]      n_reg, n_next;
    logic [9:0]      k_reg, k_next;
    logic [2:0]      step_reg, step_next;
    logic            dec;
    logic [1:0]      thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bf_pkg::ST_IDLE;
            phase_reg <= bf_pkg::PH_USER;
            rnd_reg   <= 4'd0;
            n_reg     <= 5'd0;
            k_reg     <= 10'd0;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
        end
    end

    assign dec = (phase_reg == bf_pkg::PH_USER) && (status.op == bf_pkg::OP_DEC);
    assign thr = (step_reg == 3'd3) ? 2'd3 : step_reg[1:0] + 2'd1;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.src    = phase_reg;
        cmd.pair   = k_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        case (state_reg)
            // Take a request and dispatch on its operation
            bf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (status.in_valid)
                begin
                    case (status.in_op)
                        bf_pkg::OP_LOAD: state_next = bf_pkg::ST_LOAD;
                        bf_pkg::OP_KEY:  state_next = bf_pkg::ST_SEED;
                        default:
                        begin
                            phase_next = bf_pkg::PH_USER;
                            state_next = bf_pkg::ST_C_START;
                        end
                    endcase
                end
            end
            bf_pkg::ST_LOAD:
            begin
                cmd.tw_we   = 1'b1;
                cmd.tw_src  = bf_pkg::TW_IN;
                cmd.blk_clr = 1'b1;
                state_next  = bf_pkg::ST_RESP;
            end
            bf_pkg::ST_SEED:
            begin
                cmd.kw_op  = bf_pkg::KW_SEED;
                step_next  = 3'd0;
                state_next = bf_pkg::ST_STEP;
            end
            // Walk the key init steps: pass, pass, shift, pass
            bf_pkg::ST_STEP:
            begin
                if (step_reg == 3'd2)
                begin
                    cmd.kw_op = bf_pkg::KW_SHIFT;
                    step_next = 3'd3;
                end
                else if (step_reg == 3'd4)
                begin
                    cmd.blk_clr = 1'b1;
                    state_next  = bf_pkg::ST_RESP;
                end
                else if (status.level >= thr)
                begin
                    phase_next = bf_pkg::PH_KW12;
                    state_next = bf_pkg::ST_C_START;
                end
                else
                    step_next = step_reg + 3'd1;
            end
            // Cipher: load block, then an address step and a mix step per round
            bf_pkg::ST_C_START:
            begin
                cmd.start  = 1'b1;
                rnd_next   = 4'd0;
                state_next = bf_pkg::ST_C_ADDR;
            end
            bf_pkg::ST_C_ADDR:
            begin
                cmd.addr   = 1'b1;
                cmd.p_idx  = dec ? 5'd17 - {1'b0, rnd_reg} : {1'b0, rnd_reg};
                state_next = bf_pkg::ST_C_MIX;
            end
            bf_pkg::ST_C_MIX:
            begin
                cmd.mix  = 1'b1;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'(bf_pkg::ROUNDS - 1))
                    state_next = bf_pkg::ST_C_FIN_LO;
                else
                    state_next = bf_pkg::ST_C_ADDR;
            end
            bf_pkg::ST_C_FIN_LO:
            begin
                cmd.fin_lo = 1'b1;
                cmd.p_idx  = dec ? 5'd1 : 5'd16;
                state_next = bf_pkg::ST_C_FIN_HI;
            end
            bf_pkg::ST_C_FIN_HI:
            begin
                cmd.fin_hi = 1'b1;
                cmd.p_idx  = dec ? 5'd0 : 5'd17;
                case (phase_reg)
                    bf_pkg::PH_USER: state_next = bf_pkg::ST_RESP;
                    bf_pkg::PH_RW:   state_next = bf_pkg::ST_RW_HI;
                    default:         state_next = bf_pkg::ST_KW_CMT;
                endcase
            end
            // Store the encrypted key words
            bf_pkg::ST_KW_CMT:
            begin
                if (phase_reg == bf_pkg::PH_KW12)
                begin
                    cmd.kw_op  = bf_pkg::KW_CMT12;
                    phase_next = bf_pkg::PH_KW01;
                    state_next = bf_pkg::ST_C_START;
                end
                else
                begin
                    cmd.kw_op    = bf_pkg::KW_CMT01;
                    cmd.byte_clr = 1'b1;
                    n_next       = 5'd0;
                    state_next   = bf_pkg::ST_PMIX;
                end
            end
            // Mix key words into P, one word a cycle
            bf_pkg::ST_PMIX:
            begin
                cmd.pmix  = 1'b1;
                cmd.p_idx = n_reg;
                n_next    = n_reg + 5'd1;
                if (n_reg == 5'(bf_pkg::P_WORDS - 1))
                begin
                    cmd.blk_clr = 1'b1;
                    k_next      = 10'd0;
                    phase_next  = bf_pkg::PH_RW;
                    state_next  = bf_pkg::ST_C_START;
                end
            end
            // Rewrite the table two words per encryption
            bf_pkg::ST_RW_HI:
            begin
                cmd.tw_we  = 1'b1;
                cmd.tw_src = bf_pkg::TW_HI;
                state_next = bf_pkg::ST_RW_LO;
            end
            bf_pkg::ST_RW_LO:
            begin
                cmd.tw_we  = 1'b1;
                cmd.tw_src = bf_pkg::TW_LO;
                if (k_reg == 10'(bf_pkg::RW_PAIRS - 1))
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = bf_pkg::ST_STEP;
                end
                else
                begin
                    k_next     = k_reg + 10'd1;
                    state_next = bf_pkg::ST_C_START;
                end
            end
            // Hold the result until taken
            bf_pkg::ST_RESP:
            begin
                out_valid = 1'b1;
                if (status.out_ready)
                    state_next = bf_pkg::ST_IDLE;
            end
            default:
                state_next = bf_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/blowfish_block_cipher_with_key_schedule.sv =====
// Blowfish engine with table load, encrypt, decrypt and key schedule.
//
// Requests arrive on req (valid/ready) and carry an operation: load one
// table word, encrypt or decrypt a 64-bit block, or run key init. Every
// request yields exactly one response on res (valid/ready); it holds the
// cipher output, or zero for load and key init.
// One request is in flight at a time: req.ready is high only while idle.
// Load writes the table word; encrypt and decrypt load the block, run each
// round as an address step that reads the four S-box memories and a mix
// step that combines their registered data, then whiten the low and high
// halves.
// A key schedule pass runs 520 encryptions, each followed by its two table
// writes, plus the two key word encryptions and key mixing; key init runs
// up to three such passes, following key_level.
// The response stays on res until res.ready is seen; stalls only delay it.
// Reset clears the control state and the key words and sets the wrap
// register to 12; the table holds nothing defined until loaded, and there
// is no clearing pass. Write the wrap register only while idle.
module blowfish_block_cipher_with_key_schedule #(
    parameter int TABLE_WORDS = bf_pkg::TABLE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bf_req_if.sink      req,
    bf_res_if.source    res,
    input  logic        key_wrap_we,
    input  logic [3:0]  key_wrap_data
);

    bf_pkg::cmd_t    cmd;
    bf_pkg::status_t status;
    bf_pkg::op_t     op;
    logic [1:0]      level;
    logic            in_ready;
    logic            out_valid;

    assign status.in_valid  = req.valid;
    assign status.in_op     = bf_pkg::op_t'(req.operation);
    assign status.out_ready = res.ready;
    assign status.op        = op;
    assign status.level     = level;

    assign req.ready = in_ready;
    assign res.valid = out_valid;

    bf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    bf_datapath #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cap            (req.valid && in_ready),
        .in_operation   (req.operation),
        .in_table_index (req.table_index),
        .in_table_data  (req.table_data),
        .in_block_low   (req.block_low),
        .in_block_high  (req.block_high),
        .in_id_code     (req.id_code),
        .in_key_level   (req.key_level),
        .key_wrap_we    (key_wrap_we),
        .key_wrap_data  (key_wrap_data),
        .cmd            (cmd),
        .op             (op),
        .level          (level),
        .out_low        (res.out_low),
        .out_high       (res.out_high)
    );

endmodule
